[hw/rtl/fit_downscaler_with_blending_defines.svh]
// Assertion macros shared by the downscaler checker.
// No dependencies; included by the checker file.
`ifndef FIT_DOWNSCALER_WITH_BLENDING_DEFINES_SVH
`define FIT_DOWNSCALER_WITH_BLENDING_DEFINES_SVH

// Same-cycle implication, inactive while reset is high.
`define FDB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, inactive while reset is high.
`define FDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define FDB_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/fdb_pkg.sv]
// Shared types, constants and the RGB565 averaging function for the downscaler.
// No dependencies.
package fdb_pkg;

   localparam int MAX_COLUMNS = 512;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int PIX_W       = 16;
   localparam int OUT_COL_W   = 9;
   localparam int ACC_W       = 14;
   localparam int CFG_W       = 12;
   localparam int CNT_W       = 10;
   localparam int CSR_ADDR_W  = 3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_STEP_X         = 3'd0,
      REG_MODULO_X       = 3'd1,
      REG_STEP_Y         = 3'd2,
      REG_MODULO_Y       = 3'd3,
      REG_SOURCE_COLUMNS = 3'd4,
      REG_SOURCE_LINES   = 3'd5,
      REG_BLEND_ROWS     = 3'd6
   } fdb_reg_type;

   // Per-request control decided at accept time, consumed by the pixel stage.
   typedef struct packed {
      logic             avg_held;   // average with held pixel
      logic             merge;      // average with stored row pixel
      logic             wr;         // write result to line store
      logic             emit_out;   // produces a response
      logic             active;     // row takes part (blend or final row)
      logic             last_col;
      logic             frame_end;
      logic [COL_W-1:0] dst;
   } fdb_ctl_type;

   function automatic logic [PIX_W-1:0] avg565(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
      logic [5:0] r;
      logic [6:0] g;
      logic [5:0] bl;
      r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
      g  = {1'b0, a[10:5]}  + {1'b0, b[10:5]};
      bl = {1'b0, a[4:0]}   + {1'b0, b[4:0]};
      return {r[5:1], g[6:1], bl[5:1]};
   endfunction

endpackage

[hw/rtl/fit_downscaler_with_blending.sv]
// Fit-to-screen RGB565 downscaler with optional row blending, top level.
// Depends on fdb_pkg and fdb_line_store.
//
// Usage:
//  - req_*: source pixels in raster order, one request per pixel.
//  - rsp_*: scaled pixels; tdata = {out_column, pixel_out}, tlast marks the
//    end of an output line, tuser the end of the frame. Pixels that are not
//    emitted produce no response.
//  - csr_*: register write port (step_x, modulo_x, step_y, modulo_y,
//    source_columns, source_lines, blend_rows), written while idle.
// Throughput: one request per cycle while the output is not stalled. An
// accepted request passes the control stage, then the pixel stage that reads
// the line store and fills the output register.
// The line store is a 512 x 16 memory with one write and one registered
// read port; same-edge write/read hazards are forwarded.
// Reset: synchronous; counters, accumulators and valids clear, registers
// take their defaults. The line store is not cleared.
// Stall: when rsp_tready is low, the output register holds and the pipe
// fills; req_tready drops only once the control stage holds a request that
// must produce a response.
module fit_downscaler_with_blending (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // [15:0] pixel_in
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [15:0] pixel_out, [24:16] out_column
   output logic                            rsp_tlast,   // line_end
   output logic                            rsp_tuser,   // frame_end
   input  logic                            csr_we,
   input  logic [fdb_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [fdb_pkg::CFG_W-1:0]       csr_wdata
);
   import fdb_pkg::*;

   // configuration
   logic [CFG_W-1:0] step_x_ff, modulo_x_ff, step_y_ff, modulo_y_ff;
   logic [CNT_W-1:0] src_cols_ff, src_lines_ff;
   logic             blend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff    <= CFG_W'(3);
         modulo_x_ff  <= CFG_W'(4);
         step_y_ff    <= CFG_W'(3);
         modulo_y_ff  <= CFG_W'(4);
         src_cols_ff  <= CNT_W'(320);
         src_lines_ff <= CNT_W'(240);
         blend_ff     <= 1'b1;
      end else if (csr_we) begin
         case (fdb_reg_type'(csr_addr))
            REG_STEP_X:         step_x_ff    <= csr_wdata;
            REG_MODULO_X:       modulo_x_ff  <= csr_wdata;
            REG_STEP_Y:         step_y_ff    <= csr_wdata;
            REG_MODULO_Y:       modulo_y_ff  <= csr_wdata;
            REG_SOURCE_COLUMNS: src_cols_ff  <= csr_wdata[CNT_W-1:0];
            REG_SOURCE_LINES:   src_lines_ff <= csr_wdata[CNT_W-1:0];
            REG_BLEND_ROWS:     blend_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // control state
   logic [ACC_W-1:0] acc_h_ff, acc_h_in, acc_v_ff, acc_v_in;
   logic [COL_W-1:0] col_cnt_ff, col_cnt_in, dst_cnt_ff, dst_cnt_in;
   logic [CNT_W-1:0] row_cnt_ff, row_cnt_in;
   logic             merge_ff, merge_in;

   // stage 1 (accepted request)
   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff;
   fdb_ctl_type      s1_ctl_ff, ctl_in;
   logic             s1_adv, accept;

   // pixel stage / output
   logic [PIX_W-1:0] held_ff, held_in;
   logic [PIX_W-1:0] store_rd, pix_a, pix_b;
   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_pix_ff;
   logic [COL_W-1:0] out_col_ff;
   logic             out_lend_ff, out_fend_ff;

   logic [COL_W-1:0] col_last;
   logic [CNT_W-1:0] row_last;
   logic             last_col, last_row, final_row, active, emit;
   logic [ACC_W:0]   hsum, vsum;

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready || !s1_ctl_ff.emit_out);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      // last column index: zero count acts as one, clamp to the store depth
      if (src_cols_ff == '0) begin
         col_last = '0;
      end else if (32'(src_cols_ff) > MAX_COLUMNS) begin
         col_last = COL_W'(MAX_COLUMNS - 1);
      end else begin
         col_last = COL_W'(src_cols_ff - CNT_W'(1));
      end
      row_last  = (src_lines_ff == '0) ? '0 : src_lines_ff - CNT_W'(1);
      last_col  = col_cnt_ff >= col_last;
      last_row  = row_cnt_ff >= row_last;
      vsum      = {1'b0, acc_v_ff} + (ACC_W+1)'(step_y_ff);
      final_row = (vsum >= (ACC_W+1)'(modulo_y_ff)) || last_row;
      active    = blend_ff || final_row;
      hsum      = {1'b0, acc_h_ff} + (ACC_W+1)'(step_x_ff);
      emit      = active && ((hsum >= (ACC_W+1)'(modulo_x_ff)) || last_col);

      ctl_in.avg_held  = active && (acc_h_ff >= ACC_W'(step_x_ff));
      ctl_in.merge     = emit && blend_ff && merge_ff;
      ctl_in.wr        = emit && blend_ff;
      ctl_in.emit_out  = emit && final_row;
      ctl_in.active    = active;
      ctl_in.last_col  = last_col;
      ctl_in.frame_end = last_col && last_row;
      ctl_in.dst       = dst_cnt_ff;

      acc_h_in   = acc_h_ff;
      dst_cnt_in = dst_cnt_ff;
      if (active) begin
         acc_h_in = emit ? ACC_W'(hsum - (ACC_W+1)'(modulo_x_ff)) : ACC_W'(hsum);
      end
      if (emit) begin
         dst_cnt_in = dst_cnt_ff + COL_W'(1);
      end
      acc_v_in   = acc_v_ff;
      row_cnt_in = row_cnt_ff;
      merge_in   = merge_ff;
      col_cnt_in = col_cnt_ff + COL_W'(1);
      if (last_col) begin
         acc_h_in   = '0;
         col_cnt_in = '0;
         dst_cnt_in = '0;
         if (last_row) begin
            acc_v_in   = '0;
            row_cnt_in = '0;
            merge_in   = 1'b0;
         end else begin
            acc_v_in   = final_row ? ACC_W'(vsum - (ACC_W+1)'(modulo_y_ff)) : ACC_W'(vsum);
            row_cnt_in = row_cnt_ff + CNT_W'(1);
            merge_in   = blend_ff && !final_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_h_ff   <= '0;
         acc_v_ff   <= '0;
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         dst_cnt_ff <= '0;
         merge_ff   <= 1'b0;
      end else if (accept) begin
         acc_h_ff   <= acc_h_in;
         acc_v_ff   <= acc_v_in;
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         dst_cnt_ff <= dst_cnt_in;
         merge_ff   <= merge_in;
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff <= req_tdata;
         s1_ctl_ff <= ctl_in;
      end
   end

   fdb_line_store u_store (
      .clock   (clock),
      .wr_en   (s1_adv && s1_ctl_ff.wr),
      .wr_addr (s1_ctl_ff.dst),
      .wr_data (pix_b),
      .rd_en   (accept),
      .rd_addr (dst_cnt_ff),
      .rd_data (store_rd)
   );

   // pixel stage: horizontal average, then row merge
   always_comb begin
      pix_a = s1_ctl_ff.avg_held ? avg565(held_ff, s1_pix_ff) : s1_pix_ff;
      pix_b = s1_ctl_ff.merge ? avg565(store_rd, pix_a) : pix_a;
      held_in = held_ff;
      if (s1_ctl_ff.last_col) begin
         held_in = '0;
      end else if (s1_ctl_ff.active) begin
         held_in = pix_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (s1_adv) begin
         held_ff <= held_in;
      end
   end

   assign out_valid_in = (s1_adv && s1_ctl_ff.emit_out) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_ctl_ff.emit_out) begin
         out_pix_ff  <= pix_b;
         out_col_ff  <= s1_ctl_ff.dst;
         out_lend_ff <= s1_ctl_ff.last_col;
         out_fend_ff <= s1_ctl_ff.frame_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, OUT_COL_W'(out_col_ff), out_pix_ff};
   assign rsp_tlast  = out_lend_ff;
   assign rsp_tuser  = out_fend_ff;

endmodule

[hw/rtl/fdb_line_store.sv]
// Single-port-write, single-port-read line store with registered read data
// and write-to-read bypass. Depends on fdb_pkg.
module fdb_line_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [fdb_pkg::COL_W-1:0]   wr_addr,
   input  logic [fdb_pkg::PIX_W-1:0]   wr_data,
   input  logic                        rd_en,
   input  logic [fdb_pkg::COL_W-1:0]   rd_addr,
   output logic [fdb_pkg::PIX_W-1:0]   rd_data
);
   import fdb_pkg::*;

   logic [PIX_W-1:0] mem [MAX_COLUMNS];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // a write landing on the same edge as the read is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/fdb_checker.sv]
// Port-level checker for the downscaler and its bind to the top level.
// Depends on fit_downscaler_with_blending_defines.svh.
`include "fit_downscaler_with_blending_defines.svh"

module fdb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // a stalled response keeps its payload
   `FDB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser),
      "stalled response changed")

   // end of frame is always also end of line
   `FDB_ASSERT_NOW(a_frame_line, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "frame end without line end")

   `FDB_ASSERT_ALWAYS(a_rst_rsp, clock, reset, !rsp_tvalid, "response valid after reset")

   `FDB_ASSERT_ALWAYS(a_rst_req, clock, reset, req_tready, "request side not ready after reset")

endmodule

bind fit_downscaler_with_blending fdb_checker u_fdb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

[test/tb_fit_downscaler_with_blending.sv]
`timescale 1ns / 1ps
// Self-checking bench for fit_downscaler_with_blending: random RGB565 frames under many scale
// settings, results predicted in-bench and compared per field. Needs fdb_pkg and the RTL only.
module tb_fit_downscaler_with_blending;
   import fdb_pkg::*;

   typedef struct packed {
      logic [15:0] pixel;
      logic [8:0]  column;
      logic        line_end;
      logic        frame_end;
   } scaled_pixel_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic              rsp_tlast;
   logic              rsp_tuser;
   logic              csr_we     = 1'b0;
   fdb_reg_type       csr_addr   = REG_STEP_X;
   logic [CFG_W-1:0]  csr_wdata  = '0;

   // register shadow, reset values
   logic [11:0] step_x_cfg = 12'd3, mod_x_cfg = 12'd4;
   logic [11:0] step_y_cfg = 12'd3, mod_y_cfg = 12'd4;
   logic [9:0]  cols_cfg   = 10'd320, lines_cfg = 10'd240;
   logic        blend_cfg  = 1'b1;

   // scaler state
   logic [13:0] acc_h = '0, acc_v = '0;
   logic [15:0] held = '0;
   int          col_cnt = 0, row_cnt = 0, dst_cnt = 0;
   logic        merge_pend = 1'b0;
   logic [15:0] row_store [MAX_COLUMNS];

   scaled_pixel_type due_pixels[$];
   logic [15:0]      source_q[$];

   int mismatches = 0, results_checked = 0, pixels_sent = 0, pixels_used = 0;
   int settings_run = 0, wide_runs = 0;
   int req_gap = 0, rsp_hold = 0;
   logic steady = 1'b0;

   fit_downscaler_with_blending dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("fit_downscaler_with_blending: mismatch");
      $finish;
   end

   function automatic logic [15:0] mix565(input logic [15:0] a, input logic [15:0] b);
      logic [5:0] red, blue;
      logic [6:0] green;
      red   = {1'b0, a[15:11]} + {1'b0, b[15:11]};
      green = {1'b0, a[10:5]} + {1'b0, b[10:5]};
      blue  = {1'b0, a[4:0]} + {1'b0, b[4:0]};
      return {red[5:1], green[6:1], blue[5:1]};
   endfunction

   function automatic int eff_cols();
      if (cols_cfg == 0) return 1;
      if (cols_cfg > MAX_COLUMNS) return MAX_COLUMNS;
      return int'(cols_cfg);
   endfunction

   function automatic int eff_rows();
      return (lines_cfg == 0) ? 1 : int'(lines_cfg);
   endfunction

   // pixels still needed to close the current frame
   function automatic int frame_remaining();
      int c, r, row_left;
      c = eff_cols();
      r = eff_rows();
      row_left = (col_cnt >= c - 1) ? 1 : c - col_cnt;
      return row_left + ((row_cnt >= r - 1) ? 0 : (r - 1 - row_cnt)) * c;
   endfunction

   task automatic scale_pixel(input logic [15:0] pix_in);
      logic [15:0]      pix;
      logic [31:0]      hsum, vsum;
      logic             last_col, last_row, final_row;
      int               d;
      scaled_pixel_type item;
      pix       = pix_in;
      last_col  = col_cnt >= eff_cols() - 1;
      last_row  = row_cnt >= eff_rows() - 1;
      vsum      = 32'(acc_v) + 32'(step_y_cfg);
      final_row = (vsum >= 32'(mod_y_cfg)) || last_row;
      pixels_sent++;
      if (blend_cfg || final_row) begin
         pixels_used++;
         if (acc_h >= 14'(step_x_cfg)) pix = mix565(held, pix);
         hsum = 32'(acc_h) + 32'(step_x_cfg);
         if (hsum >= 32'(mod_x_cfg) || last_col) begin
            d = dst_cnt;
            if (blend_cfg && d < MAX_COLUMNS) begin
               if (merge_pend) pix = mix565(row_store[d], pix);
               row_store[d] = pix;
            end
            if (final_row) begin
               item.pixel     = pix;
               item.column    = d[8:0];
               item.line_end  = last_col;
               item.frame_end = last_col && last_row;
               due_pixels.push_back(item);
            end
            dst_cnt = d + 1;
            hsum    = hsum - 32'(mod_x_cfg);
         end
         held  = pix;
         acc_h = hsum[13:0];
      end
      if (last_col) begin
         acc_h   = '0;
         held    = '0;
         col_cnt = 0;
         dst_cnt = 0;
         if (last_row) begin
            acc_v      = '0;
            row_cnt    = 0;
            merge_pend = 1'b0;
         end else begin
            if (final_row) vsum = vsum - 32'(mod_y_cfg);
            acc_v      = vsum[13:0];
            row_cnt++;
            merge_pend = blend_cfg && !final_row;
         end
      end else begin
         col_cnt++;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 40) $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_result();
      scaled_pixel_type want;
      if (due_pixels.size() == 0) begin
         report_mismatch("response with nothing pending", rsp_tdata, 0);
      end else begin
         want = due_pixels.pop_front();
         if (rsp_tdata[15:0] !== want.pixel)
            report_mismatch("pixel_out", 32'(rsp_tdata[15:0]), 32'(want.pixel));
         if (rsp_tdata[24:16] !== want.column)
            report_mismatch("out_column", 32'(rsp_tdata[24:16]), 32'(want.column));
         if (rsp_tdata[31:25] !== 7'd0)
            report_mismatch("tdata padding", 32'(rsp_tdata[31:25]), 0);
         if (rsp_tlast !== want.line_end)
            report_mismatch("line_end", 32'(rsp_tlast), 32'(want.line_end));
         if (rsp_tuser !== want.frame_end)
            report_mismatch("frame_end", 32'(rsp_tuser), 32'(want.frame_end));
      end
      results_checked++;
   endtask

   // mostly back-to-back, some short gaps, rare long ones
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] random_pixel();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [11:0] corner_value();
      case ($urandom_range(0, 2))
         0:       return 12'd0;
         1:       return 12'd1;
         default: return 12'd4095;
      endcase
   endfunction

   // request driver; the shadow scaler advances on every accepted pixel
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) scale_pixel(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (source_q.size() != 0) begin
               req_tdata  <= source_q.pop_front();
               req_tvalid <= 1'b1;
               req_gap = steady ? 0 : idle_length();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random backpressure
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(0, 5) == 0) rsp_hold = idle_length() + 1;
      end
   end

   // only while idle; returns at a falling edge
   task automatic write_reg(input fdb_reg_type idx, input logic [11:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_STEP_X:         step_x_cfg = value;
         REG_MODULO_X:       mod_x_cfg  = value;
         REG_STEP_Y:         step_y_cfg = value;
         REG_MODULO_Y:       mod_y_cfg  = value;
         REG_SOURCE_COLUMNS: cols_cfg   = value[9:0];
         REG_SOURCE_LINES:   lines_cfg  = value[9:0];
         REG_BLEND_ROWS:     blend_cfg  = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      while (source_q.size() != 0 || req_tvalid || due_pixels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_random(input int count);
      repeat (count) source_q.push_back(random_pixel());
   endtask

   task automatic pick_ratio(output logic [11:0] step, output logic [11:0] modulo);
      case ($urandom_range(0, 9))
         6: begin
            step   = corner_value();
            modulo = corner_value();
         end
         7: begin
            step   = 12'($urandom());
            modulo = 12'($urandom());
         end
         8: begin  // step well above modulo, accumulator wraps
            step   = 12'($urandom_range(1000, 4095));
            modulo = 12'($urandom_range(0, 40));
         end
         9: begin
            step   = 12'($urandom_range(1, 3));
            modulo = 12'($urandom_range(100, 4095));
         end
         default: begin
            step   = 12'($urandom_range(1, 7));
            modulo = 12'($urandom_range(1, 9));
         end
      endcase
   endtask

   task automatic random_phase();
      logic [11:0] sx, mx, sy, my, cols, lines, blend_word;
      logic        wide;
      int          frames, split;
      pick_ratio(sx, mx);
      pick_ratio(sy, my);
      wide       = (settings_run == 0) || (wide_runs < 2 && $urandom_range(0, 24) == 0);
      frames     = $urandom_range(1, 3);
      blend_word = 12'($urandom());
      if (wide) begin
         wide_runs++;
         if (settings_run == 0) mx = sx;  // every column emitted
         if ($urandom_range(0, 1)) begin
            cols = 12'd512;
         end else begin
            cols        = 12'($urandom_range(513, 1023));
            cols[11:10] = 2'($urandom_range(0, 3));
         end
         lines  = 12'($urandom_range(0, 1));
         frames = 1;
      end else begin
         cols  = ($urandom_range(0, 15) == 0) ? 12'd0 : 12'($urandom_range(1, 20));
         lines = ($urandom_range(0, 15) == 0) ? 12'd0 : 12'($urandom_range(1, 6));
      end
      steady = ($urandom_range(0, 4) == 0);
      write_reg(REG_STEP_X, sx);
      write_reg(REG_MODULO_X, mx);
      write_reg(REG_STEP_Y, sy);
      write_reg(REG_MODULO_Y, my);
      write_reg(REG_SOURCE_COLUMNS, cols);
      write_reg(REG_SOURCE_LINES, lines);
      write_reg(REG_BLEND_ROWS, blend_word);
      settings_run++;
      // fast mode never reads the line store, so sizes may change mid-frame
      if (!blend_cfg && !wide && $urandom_range(0, 2) == 0) begin
         split = $urandom_range(1, frame_remaining());
         push_random(split);
         settle();
         if ($urandom_range(0, 1)) write_reg(REG_SOURCE_COLUMNS, 12'($urandom_range(0, 20)));
         else write_reg(REG_SOURCE_LINES, 12'($urandom_range(0, 6)));
         push_random(frame_remaining());
      end else begin
         push_random(frame_remaining() + (frames - 1) * eff_cols() * eff_rows());
      end
      settle();
   endtask

   initial begin : stimulus
      int k;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset steps, two-row blend group
      write_reg(REG_SOURCE_COLUMNS, 12'd3);
      write_reg(REG_SOURCE_LINES, 12'd2);
      source_q.push_back(16'h0000);
      source_q.push_back(16'hFFFF);
      source_q.push_back(16'hF800);
      source_q.push_back(16'h07E0);
      source_q.push_back(16'h001F);
      source_q.push_back(16'hFFFF);
      settle();

      // zero counts behave as one
      write_reg(REG_SOURCE_COLUMNS, 12'd0);
      write_reg(REG_SOURCE_LINES, 12'd0);
      source_q.push_back(16'hFFFF);
      settle();

      // zero steps and moduli in fast mode: every pixel and row emitted
      write_reg(REG_STEP_X, 12'd0);
      write_reg(REG_MODULO_X, 12'd0);
      write_reg(REG_STEP_Y, 12'd0);
      write_reg(REG_MODULO_Y, 12'd0);
      write_reg(REG_BLEND_ROWS, 12'd0);
      write_reg(REG_SOURCE_COLUMNS, 12'd3);
      write_reg(REG_SOURCE_LINES, 12'd2);
      source_q.push_back(16'hAAAA);
      source_q.push_back(16'h5555);
      source_q.push_back(16'hFFFF);
      source_q.push_back(16'h0000);
      source_q.push_back(16'h8410);
      source_q.push_back(16'h7BEF);
      settle();

      // maximal step over minimal modulo: horizontal accumulator wraps
      write_reg(REG_STEP_X, 12'd4095);
      write_reg(REG_MODULO_X, 12'd1);
      write_reg(REG_BLEND_ROWS, 12'd1);
      write_reg(REG_SOURCE_COLUMNS, 12'd6);
      write_reg(REG_SOURCE_LINES, 12'd1);
      push_random(6);
      settle();

      // oversized column count clamps, then shrinks under a running row
      write_reg(REG_BLEND_ROWS, 12'd0);
      write_reg(REG_SOURCE_COLUMNS, 12'hFFF);
      push_random(3);
      settle();
      write_reg(REG_SOURCE_COLUMNS, 12'd2);
      source_q.push_back(16'hFFFF);
      settle();

      // tallest frame, shrunk under a running frame
      write_reg(REG_SOURCE_COLUMNS, 12'd1);
      write_reg(REG_SOURCE_LINES, 12'h3FF);
      push_random(3);
      settle();
      write_reg(REG_SOURCE_LINES, 12'd2);
      source_q.push_back(16'h0000);
      settle();

      while (pixels_sent < 1850) random_phase();

      steady = 1'b0;
      while (source_q.size() != 0 || req_tvalid) @(negedge clock);
      for (k = 0; k < 4000 && due_pixels.size() != 0; k++) @(negedge clock);
      repeat (6) @(negedge clock);
      if (due_pixels.size() != 0)
         report_mismatch("results never delivered", due_pixels.size(), 0);

      $display("Ran %0d source pixels (%0d in active rows) over %0d random settings",
               pixels_sent, pixels_used, settings_run);
      $display("plus directed corners; %0d scaled pixels compared, %0d errors",
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("fit_downscaler_with_blending: match");
      end else begin
         $display("fit_downscaler_with_blending: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fdb_pkg.sv
hw/rtl/fdb_line_store.sv
hw/rtl/fit_downscaler_with_blending.sv
hw/rtl/fdb_checker.sv
test/tb_fit_downscaler_with_blending.sv
